### rtl/mbc1_bank_mapper_core_assert.svh
// ============================================================================
// MBC1 bank mapper assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ============================================================================
`ifndef MBC1_BANK_MAPPER_CORE_ASSERT_SVH
`define MBC1_BANK_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mbc1_pkg.sv
// ============================================================================
// MBC1 bank mapper package
// Result codes, bank register layout and shared decode constants.
// ============================================================================
package mbc1_pkg;

    typedef enum logic [2:0] {
        TGT_ROM_READ    = 3'd0,
        TGT_RAM_READ    = 3'd1,
        TGT_RAM_WRITE   = 3'd2,
        TGT_REG_WRITE   = 3'd3,
        TGT_UNSUPPORTED = 3'd4
    } target_t;

    localparam int unsigned AddrWidth = 16;
    localparam int unsigned DataWidth = 8;
    localparam int unsigned PhysWidth = 21;

    // Address regions, selected on the top three address bits.
    localparam logic [2:0] RegionRamEnable = 3'b000;
    localparam logic [2:0] RegionRomBank   = 3'b001;
    localparam logic [2:0] RegionUpperBank = 3'b010;
    localparam logic [2:0] RegionMode      = 3'b011;
    localparam logic [2:0] RegionRam       = 3'b101;

    localparam logic [3:0]           RamEnableKey  = 4'hA;
    localparam logic [DataWidth-1:0] OpenBusByte   = 8'hFF;
    localparam logic [4:0]           RomBankReset  = 5'd1;

    typedef struct packed {
        logic       ram_enabled;
        logic [4:0] rom_bank_low;
        logic [1:0] upper_bank;
        logic       banking_mode;
    } bank_state_t;

    typedef struct packed {
        logic                 wr_ram_enable;
        logic                 wr_rom_bank;
        logic                 wr_upper_bank;
        logic                 wr_mode;
        logic [DataWidth-1:0] data;
    } reg_update_t;

endpackage

### rtl/mbc1_decode.sv
// ============================================================================
// MBC1 access decoder
// Classifies one bus access and forms the translated address and data byte.
// ============================================================================
module mbc1_decode
    import mbc1_pkg::*;
(
    input  logic                 fire,
    input  logic                 req_type,
    input  logic [AddrWidth-1:0] bus_address,
    input  logic [DataWidth-1:0] bus_write_data,
    input  logic                 cart_has_ram,
    input  bank_state_t          bank_state,
    output target_t              target,
    output logic [PhysWidth-1:0] phys_address,
    output logic [DataWidth-1:0] out_data,
    output reg_update_t          update
);

    logic [2:0]           region;
    logic                 ram_ok;
    logic [6:0]           rom_bank;
    logic [1:0]           ram_bank;
    logic [PhysWidth-1:0] ram_phys;

    always_comb begin
        region   = bus_address[15:13];
        ram_ok   = (region == RegionRam) && bank_state.ram_enabled && cart_has_ram;
        rom_bank = bank_state.banking_mode ? {bank_state.upper_bank, bank_state.rom_bank_low}
                                           : {2'b00, bank_state.rom_bank_low};
        ram_bank = bank_state.banking_mode ? 2'b00 : bank_state.upper_bank;
        ram_phys = {6'd0, ram_bank, bus_address[12:0]};

        target       = TGT_UNSUPPORTED;
        phys_address = '0;
        out_data     = '0;
        update       = '0;
        update.data  = bus_write_data;

        if (!req_type) begin
            if (bus_address[15:14] == 2'b00) begin
                target       = TGT_ROM_READ;
                phys_address = {5'd0, bus_address};
            end else if (bus_address[15:14] == 2'b01) begin
                target       = TGT_ROM_READ;
                phys_address = {rom_bank, bus_address[13:0]};
            end else if (ram_ok) begin
                target       = TGT_RAM_READ;
                phys_address = ram_phys;
            end else begin
                out_data = OpenBusByte;
            end
        end else begin
            case (region)
                RegionRamEnable: begin
                    target               = TGT_REG_WRITE;
                    update.wr_ram_enable = fire;
                end
                RegionRomBank: begin
                    target             = TGT_REG_WRITE;
                    update.wr_rom_bank = fire;
                end
                RegionUpperBank: begin
                    target               = TGT_REG_WRITE;
                    update.wr_upper_bank = fire;
                end
                RegionMode: begin
                    target         = TGT_REG_WRITE;
                    update.wr_mode = fire;
                end
                default: begin
                    if (ram_ok) begin
                        target       = TGT_RAM_WRITE;
                        phys_address = ram_phys;
                        out_data     = bus_write_data;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/mbc1_regs.sv
// ============================================================================
// MBC1 bank registers
// Holds RAM enable, ROM bank, upper bank and banking mode.
// ============================================================================
module mbc1_regs
    import mbc1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  reg_update_t update,
    output bank_state_t bank_state
);

    bank_state_t state_reg;
    bank_state_t state_next;
    logic [4:0]  masked_bank;

    always_comb begin
        masked_bank = update.data[4:0];
        state_next  = state_reg;
        if (update.wr_ram_enable) begin
            state_next.ram_enabled = (update.data[3:0] == RamEnableKey);
        end
        if (update.wr_rom_bank) begin
            state_next.rom_bank_low = (masked_bank == 5'd0) ? RomBankReset : masked_bank;
        end
        if (update.wr_upper_bank) begin
            state_next.upper_bank = update.data[1:0];
        end
        if (update.wr_mode) begin
            state_next.banking_mode = update.data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.ram_enabled  <= 1'b0;
            state_reg.rom_bank_low <= RomBankReset;
            state_reg.upper_bank   <= 2'b00;
            state_reg.banking_mode <= 1'b0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign bank_state = state_reg;

endmodule

### rtl/mbc1_bank_mapper_core.sv
// ============================================================================
// MBC1 bank mapper core
// Translates CPU bus accesses into cartridge ROM/RAM addresses and bank writes.
// ============================================================================
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    req_type, bus_address, bus_write_data
//  m_        out        m_valid/m_ready    target, phys_address, out_data
//  cfg_      in         cfg_wr_en          cfg_wr_data (cartridge has RAM)
//
// An item passes through the input register and then the result register;
// one item per cycle is sustained while m_ready is held high.
// Bank register writes take effect for the very next item.
// Reset is synchronous; it clears both stages and restores bank 1, RAM off.
// A stall on m_ready holds the result register and then the input register.
// ============================================================================
`include "mbc1_bank_mapper_core_assert.svh"

module mbc1_bank_mapper_core
    import mbc1_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [AddrWidth-1:0] s_bus_address,
    input  logic [DataWidth-1:0] s_bus_write_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_target,
    output logic [PhysWidth-1:0] m_phys_address,
    output logic [DataWidth-1:0] m_out_data
);

    logic                 cart_has_ram_reg;
    logic                 in_valid_reg;
    logic                 in_req_type_reg;
    logic [AddrWidth-1:0] in_addr_reg;
    logic [DataWidth-1:0] in_data_reg;
    logic                 out_valid_reg;
    target_t              out_target_reg;
    logic [PhysWidth-1:0] out_phys_reg;
    logic [DataWidth-1:0] out_data_reg;

    logic                 out_ready;
    logic                 advance;
    logic                 s_fire;
    target_t              dec_target;
    logic [PhysWidth-1:0] dec_phys;
    logic [DataWidth-1:0] dec_data;
    reg_update_t          update;
    bank_state_t          bank_state;

    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign s_fire    = s_valid && s_ready;

    mbc1_decode u_decode (
        .fire           (advance),
        .req_type       (in_req_type_reg),
        .bus_address    (in_addr_reg),
        .bus_write_data (in_data_reg),
        .cart_has_ram   (cart_has_ram_reg),
        .bank_state     (bank_state),
        .target         (dec_target),
        .phys_address   (dec_phys),
        .out_data       (dec_data),
        .update         (update)
    );

    mbc1_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (update),
        .bank_state (bank_state)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cart_has_ram_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cart_has_ram_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_type_reg <= s_req_type;
            in_addr_reg     <= s_bus_address;
            in_data_reg     <= s_bus_write_data;
        end
        if (advance) begin
            out_target_reg <= dec_target;
            out_phys_reg   <= dec_phys;
            out_data_reg   <= dec_data;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_target       = out_target_reg;
    assign m_phys_address = out_phys_reg;
    assign m_out_data     = out_data_reg;

    `MBC_ASSERT_IMPLY(a_rom_bank_nonzero, aclk, aresetn, 1'b1,
        bank_state.rom_bank_low != 5'd0, "ROM bank register holds zero")
    `MBC_ASSERT_IMPLY(a_reg_write_zero, aclk, aresetn,
        m_valid && (m_target == TGT_REG_WRITE),
        (m_phys_address == '0) && (m_out_data == '0),
        "register write result carries address or data")
    `MBC_ASSERT_NEXT(a_mode_update, aclk, aresetn,
        advance && in_req_type_reg && (in_addr_reg[15:13] == RegionMode),
        bank_state.banking_mode == $past(in_data_reg[0]),
        "banking mode not taken from mode write")

endmodule

### tb/mbc1_bank_mapper_core_test.sv
// ============================================================================
// MBC1 bank mapper core testbench
// Sends CPU bus accesses through the valid/ready input channel and predicts
// each result from a private copy of the bank registers and the cartridge RAM
// setting. Results are checked field by field, in order. A directed sequence
// covers the region edges, bank zero remapping, both banking modes and RAM
// gating. Random phases follow, each with its own cartridge RAM setting. Both
// channels idle and stall at random.
// ============================================================================
module mbc1_bank_mapper_core_test;
    import mbc1_pkg::*;

    localparam int IdleLimit = 500;
    localparam int PhaseCount = 8;
    localparam int PhaseItems = 240;

    typedef struct {
        target_t              tgt;
        logic [PhysWidth-1:0] phys;
        logic [DataWidth-1:0] data;
    } mapped_access_t;

    class bank_map_scoreboard;
        bank_state_t    banks;
        logic           cart_ram;
        mapped_access_t expected_accesses[$];
        int             errors;

        function new();
            banks.ram_enabled  = 1'b0;
            banks.rom_bank_low = RomBankReset;
            banks.upper_bank   = 2'd0;
            banks.banking_mode = 1'b0;
            cart_ram = 1'b0;
            errors = 0;
        endfunction

        function void set_cart_ram(input logic value);
            cart_ram = value;
        endfunction

        function int pending();
            return expected_accesses.size();
        endfunction

        // Works out the result of one access and applies any bank register write.
        function void note_access(input logic wr, input logic [AddrWidth-1:0] addr,
                                  input logic [DataWidth-1:0] d);
            mapped_access_t r;
            logic           ram_ok;
            logic [1:0]     ram_bank;
            logic [6:0]     rom_bank;
            ram_ok = (addr[15:13] == RegionRam) && banks.ram_enabled && cart_ram;
            ram_bank = banks.banking_mode ? 2'd0 : banks.upper_bank;
            r.tgt = TGT_REG_WRITE;
            r.phys = '0;
            r.data = '0;
            if (!wr) begin
                if (addr < 16'h4000) begin
                    r.tgt = TGT_ROM_READ;
                    r.phys = {5'd0, addr};
                end else if (addr < 16'h8000) begin
                    rom_bank = banks.banking_mode ? {banks.upper_bank, banks.rom_bank_low}
                                                  : {2'b00, banks.rom_bank_low};
                    r.tgt = TGT_ROM_READ;
                    r.phys = {rom_bank, addr[13:0]};
                end else if (ram_ok) begin
                    r.tgt = TGT_RAM_READ;
                    r.phys = {6'd0, ram_bank, addr[12:0]};
                end else begin
                    r.tgt = TGT_UNSUPPORTED;
                    r.data = OpenBusByte;
                end
            end else begin
                case (addr[15:13])
                    RegionRamEnable: banks.ram_enabled = (d[3:0] == RamEnableKey);
                    RegionRomBank: begin
                        banks.rom_bank_low = (d[4:0] == 5'd0) ? RomBankReset : d[4:0];
                    end
                    RegionUpperBank: banks.upper_bank = d[1:0];
                    RegionMode: banks.banking_mode = d[0];
                    default: begin
                        if (ram_ok) begin
                            r.tgt = TGT_RAM_WRITE;
                            r.phys = {6'd0, ram_bank, addr[12:0]};
                            r.data = d;
                        end else begin
                            r.tgt = TGT_UNSUPPORTED;
                        end
                    end
                endcase
            end
            expected_accesses.push_back(r);
        endfunction

        function void check_access_result(input logic [2:0] tgt,
                                          input logic [PhysWidth-1:0] phys,
                                          input logic [DataWidth-1:0] data);
            mapped_access_t e;
            if (expected_accesses.size() == 0) begin
                $display("%0t: unexpected result target %0d phys %h data %h",
                         $time, tgt, phys, data);
                errors++;
                return;
            end
            e = expected_accesses.pop_front();
            if (e.tgt !== tgt) begin
                $display("%0t: target expected %0d actual %0d", $time, e.tgt, tgt);
                errors++;
            end
            if (e.phys !== phys) begin
                $display("%0t: phys_address expected %h actual %h", $time, e.phys, phys);
                errors++;
            end
            if (e.data !== data) begin
                $display("%0t: out_data expected %h actual %h", $time, e.data, data);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = 1'b0;
    logic [AddrWidth-1:0] s_bus_address = '0;
    logic [DataWidth-1:0] s_bus_write_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_target;
    logic [PhysWidth-1:0] m_phys_address;
    logic [DataWidth-1:0] m_out_data;

    bank_map_scoreboard board = new();
    int idle_cycles = 0;
    int rx_stall_left = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    mbc1_bank_mapper_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_bus_address   (s_bus_address),
        .s_bus_write_data(s_bus_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target        (m_target),
        .m_phys_address  (m_phys_address),
        .m_out_data      (m_out_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                board.set_cart_ram(cfg_wr_data);
            end
            if (s_valid && s_ready) begin
                board.note_access(s_req_type, s_bus_address, s_bus_write_data);
            end
            if (m_valid && m_ready) begin
                board.check_access_result(m_target, m_phys_address, m_out_data);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("mbc1_bank_mapper_core_test NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The result side draws a stall for every item it takes.
    always @(posedge aclk) begin
        int stall;
        if (m_valid && m_ready) begin
            if ($urandom_range(0, 49) == 0) begin
                rx_steady = !rx_steady;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            m_ready <= (stall == 0);
            rx_stall_left <= stall;
        end else if (!m_ready) begin
            if (rx_stall_left <= 1) begin
                m_ready <= 1'b1;
            end
            rx_stall_left <= rx_stall_left - 1;
        end
    end

    task automatic bus_access(input logic wr, input logic [AddrWidth-1:0] addr,
                              input logic [DataWidth-1:0] d);
        int gap;
        if ($urandom_range(0, 49) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= wr;
        s_bus_address <= addr;
        s_bus_write_data <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic write_cart_ram(input logic value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic                 wr;
        logic [AddrWidth-1:0] addr;
        logic [DataWidth-1:0] d;
        int                   pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_cart_ram(1'b1);

        bus_access(1'b0, 16'h0000, 8'h00);
        bus_access(1'b0, 16'h3FFF, 8'hFF);
        bus_access(1'b0, 16'h4000, 8'h00);
        bus_access(1'b0, 16'h7FFF, 8'h00);
        bus_access(1'b0, 16'hA000, 8'h00);
        bus_access(1'b1, 16'hBFFF, 8'h55);
        bus_access(1'b1, 16'h0000, 8'h1A);
        bus_access(1'b0, 16'hA000, 8'h00);
        bus_access(1'b1, 16'hBFFF, 8'hFF);
        bus_access(1'b1, 16'h2000, 8'h00);
        bus_access(1'b0, 16'h4000, 8'h00);
        bus_access(1'b1, 16'h3FFF, 8'hE0);
        bus_access(1'b0, 16'h7FFF, 8'h00);
        bus_access(1'b1, 16'h2000, 8'h1F);
        bus_access(1'b0, 16'h7FFF, 8'h00);
        bus_access(1'b1, 16'h4000, 8'h03);
        bus_access(1'b0, 16'h7FFF, 8'h00);
        bus_access(1'b0, 16'hBFFF, 8'h00);
        bus_access(1'b1, 16'h7FFF, 8'h01);
        bus_access(1'b0, 16'h7FFF, 8'h00);
        bus_access(1'b0, 16'hA000, 8'h00);
        bus_access(1'b1, 16'h6000, 8'hFE);
        bus_access(1'b1, 16'h1FFF, 8'h0B);
        bus_access(1'b0, 16'hC000, 8'h00);
        bus_access(1'b0, 16'hFFFF, 8'h00);
        bus_access(1'b1, 16'h8000, 8'h12);

        // Most random items are register writes and accesses inside the mapped
        // regions, so that bank and mode changes are followed by reads through them.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            drain_results();
            write_cart_ram(phase % 3 != 1);
            for (int n = 0; n < PhaseItems; n++) begin
                pick = $urandom_range(0, 99);
                wr = 1'b1;
                d = DataWidth'($urandom_range(0, 255));
                if (pick < 10) begin
                    addr = AddrWidth'($urandom_range(16'h0000, 16'h1FFF));
                    if ($urandom_range(0, 9) < 7) begin
                        d[3:0] = RamEnableKey;
                    end
                end else if (pick < 20) begin
                    addr = AddrWidth'($urandom_range(16'h2000, 16'h3FFF));
                    if ($urandom_range(0, 4) == 0) begin
                        d[4:0] = 5'd0;
                    end
                end else if (pick < 28) begin
                    addr = AddrWidth'($urandom_range(16'h4000, 16'h5FFF));
                end else if (pick < 34) begin
                    addr = AddrWidth'($urandom_range(16'h6000, 16'h7FFF));
                end else if (pick < 48) begin
                    wr = 1'b0;
                    addr = AddrWidth'($urandom_range(16'h0000, 16'h3FFF));
                end else if (pick < 68) begin
                    wr = 1'b0;
                    addr = AddrWidth'($urandom_range(16'h4000, 16'h7FFF));
                end else if (pick < 88) begin
                    wr = 1'($urandom_range(0, 1));
                    addr = AddrWidth'($urandom_range(16'hA000, 16'hBFFF));
                end else begin
                    wr = 1'($urandom_range(0, 1));
                    addr = AddrWidth'($urandom_range(16'h0000, 16'hFFFF));
                end
                bus_access(wr, addr, d);
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("mbc1_bank_mapper_core_test OK");
        end else begin
            $display("mbc1_bank_mapper_core_test NOT OK");
        end
        $finish;
    end

endmodule
